>>> hdl/loop_detector_snap_trigger_macros.svh
// Assertion macros shared by the loop detector snapshot trigger RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef LOOP_DETECTOR_SNAP_TRIGGER_MACROS_SVH
`define LOOP_DETECTOR_SNAP_TRIGGER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> hdl/lds_pkg.sv
// Package for the loop detector snapshot trigger: sequencer states, field codes,
// register indexes and the result record. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package lds_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_MUL,
        S_FIN
    } t_state;

    localparam logic [2:0] REG_LANE_COUNT    = 3'd0;
    localparam logic [2:0] REG_CHANNEL_IDS   = 3'd1;
    localparam logic [2:0] REG_COIL_DISTANCE = 3'd2;
    localparam logic [2:0] REG_COIL_LENGTH   = 3'd3;
    localparam logic [2:0] REG_MODE          = 3'd4;
    localparam logic [2:0] REG_SINGLE_BEHIND = 3'd5;
    localparam logic [2:0] REG_SNAP_ON_LEAVE = 3'd6;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_CHAN_RANGE = 2'd1;
    localparam logic [1:0] ST_NO_LANE    = 2'd2;
    localparam logic [1:0] ST_BAD_COIL   = 2'd3;

    localparam logic [1:0] POS_FRONT  = 2'd0;
    localparam logic [1:0] POS_BEHIND = 2'd1;

    localparam logic [1:0] EDGE_ENTER = 2'd0;
    localparam logic [1:0] EDGE_LEAVE = 2'd1;

    localparam logic [1:0] DIR_FWD  = 2'd0;
    localparam logic [1:0] DIR_REV  = 2'd1;
    localparam logic [1:0] DIR_NONE = 2'd2;

    localparam logic [1:0] MODE_SINGLE_NOSPD = 2'd1;
    localparam logic [1:0] MODE_SINGLE_SPD   = 2'd2;

    localparam logic [1:0] STEP_NONE  = 2'd0;
    localparam logic [1:0] STEP_FIRST = 2'd1;
    localparam logic [1:0] STEP_SECOND = 2'd2;

    localparam logic [15:0] SPEED_SCALE  = 16'd36;
    localparam logic [15:0] ZERO_DIFF_MS = 16'd1000;

    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  sdir;
        logic [31:0] info;
        logic [1:0]  step;
        logic [1:0]  lane;
        logic [7:0]  port;
        logic        snap;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/loop_detector_snap_trigger.sv
// Snapshot trigger for inductive-loop detector events, built on one shared divider.
// Depends on lds_pkg and loop_detector_snap_trigger_macros.svh.
// A request goes through S_EVAL and S_FIN; a dual-coil speed adds the 32-step divider
// (S_DIV), a single-coil speed S_DIV, S_MUL and S_DIV again. A new request is taken only
// in S_IDLE, once S_FIN has passed the last result to a free output register.
// Synchronous active-low reset restores the register defaults and clears the timing state.
`timescale 1ns / 1ps
`default_nettype none
`include "loop_detector_snap_trigger_macros.svh"

module loop_detector_snap_trigger #(
    parameter int unsigned LANES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tdata from bit 0: port_id[8], detector_channel[4], coil_position[2], coil_event[2],
    // travel_direction[2], timestamp_ms[16], zero fill[6].
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    // tdata from bit 0: snap_request[1], snap_port[8], snap_lane[2], snap_step[2],
    // car_info[32], snap_direction[2], status[2], zero fill[7].
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    import lds_pkg::*;

    localparam logic [2:0]       LaneLimit = 3'(LANES);
    localparam logic [CNT_W-1:0] DivLast   = CNT_W'(DIV_STEPS - 1);

    t_state r_state, n_state;

    logic [2:0]  r_lane_count;
    logic [15:0] r_chan_ids;
    logic [63:0] r_dist;
    logic [63:0] r_clen;
    logic [7:0]  r_mode;
    logic [3:0]  r_behind;
    logic [3:0]  r_onleave;

    logic [7:0]  r_port;
    logic [3:0]  r_chan;
    logic [1:0]  r_pos;
    logic [1:0]  r_edge;
    logic [1:0]  r_dir;
    logic [15:0] r_now;

    logic [15:0] r_fe_time;
    logic [15:0] r_fl_time;
    logic [31:0] r_speed;
    logic [31:0] r_len;

    logic [1:0]  r_lane;
    logic [1:0]  r_status;
    logic        r_snap;
    logic [1:0]  r_step;
    logic [1:0]  r_sdir;
    logic        r_single;
    logic        r_with_speed;
    logic        r_div_used;
    logic        r_pass;
    logic [15:0] r_span;
    logic [15:0] r_clen_sel;

    logic [15:0]      r_rem;
    logic [31:0]      r_quo;
    logic [15:0]      r_dvs;
    logic [CNT_W-1:0] r_cnt;

    t_result r_out;
    logic    r_out_valid;

    logic        in_accept;
    logic        out_free;
    logic [2:0]  c_cnt_eff;
    logic        c_found;
    logic [1:0]  c_lane;
    logic        c_chan_ok;
    logic [1:0]  c_mode;
    logic        c_behind;
    logic        c_onleave;
    logic [15:0] c_dist;
    logic        c_single;
    logic [1:0]  c_status;
    logic        c_snap;
    logic [1:0]  c_step;
    logic [1:0]  c_sdir;
    logic        c_need_div;
    logic        c_latch_fe;
    logic        c_latch_fl;
    logic        c_clear;
    logic [15:0] c_diff;
    logic [15:0] c_divisor;
    logic [31:0] c_dividend;
    logic [16:0] d_rem_sh;
    logic        d_ge;
    logic [16:0] d_rem_nx;
    logic [31:0] m_product;
    logic [31:0] f_len;
    logic [31:0] f_info;
    t_result     f_res;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_count <= 3'd4;
            r_chan_ids   <= 16'd12816;
            r_dist       <= '0;
            r_clen       <= '0;
            r_mode       <= '0;
            r_behind     <= '0;
            r_onleave    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_LANE_COUNT:    r_lane_count <= i_cfg_data[2:0];
                REG_CHANNEL_IDS:   r_chan_ids   <= i_cfg_data[15:0];
                REG_COIL_DISTANCE: r_dist       <= i_cfg_data;
                REG_COIL_LENGTH:   r_clen       <= i_cfg_data;
                REG_MODE:          r_mode       <= i_cfg_data[7:0];
                REG_SINGLE_BEHIND: r_behind     <= i_cfg_data[3:0];
                REG_SNAP_ON_LEAVE: r_onleave    <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        c_cnt_eff = (r_lane_count > LaneLimit) ? LaneLimit : r_lane_count;
        c_found   = 1'b0;
        c_lane    = '0;
        for (int i = 0; i < LANES; i++) begin
            if (!c_found && (3'(i) < c_cnt_eff) && (r_chan_ids[4*i +: 4] == r_chan)) begin
                c_found = 1'b1;
                c_lane  = 2'(i);
            end
        end
        c_chan_ok = ({1'b0, r_chan} < 5'(LANES));
        c_mode    = r_mode[2*c_lane +: 2];
        c_behind  = r_behind[c_lane];
        c_onleave = r_onleave[c_lane];
        c_dist    = r_dist[16*c_lane +: 16];
        c_single  = (c_mode == MODE_SINGLE_NOSPD) || (c_mode == MODE_SINGLE_SPD);

        c_diff     = r_now - r_fe_time;
        c_divisor  = (c_diff == '0) ? ZERO_DIFF_MS : c_diff;
        c_dividend = 32'(c_dist) * 32'(SPEED_SCALE);

        c_status   = ST_OK;
        c_snap     = 1'b0;
        c_step     = STEP_NONE;
        c_sdir     = DIR_FWD;
        c_need_div = 1'b0;
        c_latch_fe = 1'b0;
        c_latch_fl = 1'b0;
        c_clear    = 1'b0;

        if (!c_chan_ok) begin
            c_status = ST_CHAN_RANGE;
        end else if (!c_found) begin
            c_status = ST_NO_LANE;
        end else if (c_single) begin
            if (r_pos == POS_FRONT && r_edge == EDGE_ENTER) begin
                c_clear    = 1'b1;
                c_latch_fe = 1'b1;
                c_snap     = !c_behind && !c_onleave;
            end else if (r_pos == POS_FRONT && r_edge == EDGE_LEAVE) begin
                c_latch_fl = 1'b1;
                c_snap     = !c_behind && c_onleave;
            end else if (r_pos == POS_BEHIND && r_edge == EDGE_ENTER) begin
                c_need_div = 1'b1;
                c_snap     = c_behind && !c_onleave;
            end else if (r_pos == POS_BEHIND && r_edge == EDGE_LEAVE) begin
                c_snap     = c_behind && c_onleave;
            end
            if (c_snap) begin
                c_step = STEP_FIRST;
                c_sdir = DIR_NONE;
            end
        end else if (r_dir == DIR_FWD) begin
            if (r_pos == POS_FRONT) begin
                if (r_edge == EDGE_ENTER) begin
                    c_snap     = 1'b1;
                    c_step     = STEP_FIRST;
                    c_latch_fe = 1'b1;
                end
            end else if (r_pos == POS_BEHIND) begin
                if (r_edge == EDGE_ENTER) begin
                    c_snap     = 1'b1;
                    c_step     = STEP_SECOND;
                    c_need_div = 1'b1;
                end
            end else begin
                c_status = ST_BAD_COIL;
            end
        end else if (r_dir == DIR_REV) begin
            if (r_pos == POS_BEHIND || r_pos == POS_FRONT) begin
                if (r_edge == EDGE_ENTER) begin
                    c_snap = 1'b1;
                    c_step = (r_pos == POS_BEHIND) ? STEP_FIRST : STEP_SECOND;
                    c_sdir = DIR_REV;
                end
            end else begin
                c_status = ST_BAD_COIL;
            end
        end
    end

    always_comb begin
        d_rem_sh  = {r_rem, r_quo[31]};
        d_ge      = (d_rem_sh >= {1'b0, r_dvs});
        d_rem_nx  = d_ge ? (d_rem_sh - {1'b0, r_dvs}) : d_rem_sh;
        m_product = 32'(r_quo * {16'b0, r_span});
    end

    always_comb begin
        f_len  = (r_single && r_div_used) ? (r_quo - {16'b0, r_clen_sel}) : r_len;
        f_info = '0;
        if (r_single) begin
            if (r_with_speed) begin
                f_info = {f_len[15:0], 16'b0} | r_speed;
            end
        end else if (r_div_used) begin
            f_info = r_quo;
        end
        f_res.snap   = r_snap;
        f_res.port   = r_snap ? r_port : '0;
        f_res.lane   = r_snap ? r_lane : '0;
        f_res.step   = r_snap ? r_step : '0;
        f_res.info   = r_snap ? f_info : '0;
        f_res.sdir   = r_snap ? r_sdir : '0;
        f_res.status = r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = c_need_div ? S_DIV : S_FIN;
            end
            S_DIV: begin
                if (r_cnt == DivLast) begin
                    n_state = (r_single && !r_pass) ? S_MUL : S_FIN;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_port <= s_axis_tdata[7:0];
            r_chan <= s_axis_tdata[11:8];
            r_pos  <= s_axis_tdata[13:12];
            r_edge <= s_axis_tdata[15:14];
            r_dir  <= s_axis_tdata[17:16];
            r_now  <= s_axis_tdata[33:18];
        end
        if (r_state == S_EVAL) begin
            r_lane       <= c_lane;
            r_status     <= c_status;
            r_snap       <= c_snap;
            r_step       <= c_step;
            r_sdir       <= c_sdir;
            r_single     <= c_single;
            r_with_speed <= (c_mode == MODE_SINGLE_SPD);
            r_div_used   <= c_need_div && c_chan_ok && c_found;
            r_span       <= r_fl_time - r_fe_time;
            r_clen_sel   <= r_clen[16*c_lane +: 16];
            r_rem        <= '0;
            r_quo        <= c_dividend;
            r_dvs        <= c_divisor;
        end else if (r_state == S_DIV) begin
            r_rem <= d_rem_nx[15:0];
            r_quo <= {r_quo[30:0], d_ge};
        end else if (r_state == S_MUL) begin
            r_rem <= '0;
            r_quo <= m_product;
            r_dvs <= SPEED_SCALE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pass <= 1'b0;
        end else begin
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (r_state == S_EVAL) begin
                r_pass <= 1'b0;
            end else if (r_state == S_MUL) begin
                r_pass <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fe_time <= '0;
            r_fl_time <= '0;
            r_speed   <= '0;
            r_len     <= '0;
        end else begin
            if (r_state == S_EVAL && c_chan_ok && c_found) begin
                if (c_latch_fe) begin
                    r_fe_time <= r_now;
                end
                if (c_latch_fl) begin
                    r_fl_time <= r_now;
                end
                if (c_clear) begin
                    r_speed <= '0;
                    r_len   <= '0;
                end
            end
            if (r_state == S_MUL) begin
                r_speed <= r_quo;
            end
            if (r_state == S_FIN && out_free) begin
                r_len <= f_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out <= f_res;
        end
    end

    `ASSERT_CLK(a_accept_to_eval, in_accept |=> r_state == S_EVAL,
        "accepted request did not enter evaluation")
    `ASSERT_CLK(a_nosnap_quiet,
        r_out_valid && !r_out.snap |-> r_out.port == '0 && r_out.info == '0 && r_out.step == '0,
        "result without snapshot carries payload")
    `ASSERT_NEVER(a_error_no_snap, r_out_valid && r_out.status != ST_OK && r_out.snap,
        "snapshot raised together with an error status")
    `ASSERT_CLK(a_div_exit,
        r_state == S_DIV && r_cnt == DivLast |=> r_state == S_MUL || r_state == S_FIN,
        "divider finished without leaving the divide state")

endmodule

`default_nettype wire
